>>> src/qxm_pkg.sv
package qxm_pkg;

  localparam int unsigned PULSE_W = 12;
  localparam int unsigned DUTY_W  = 14;
  localparam int unsigned CORR_W  = 12;
  localparam int unsigned MIX_W   = 17;

  localparam logic [PULSE_W-1:0] IDLE_RST = 12'd1100;
  localparam logic [PULSE_W-1:0] MAX_RST  = 12'd2000;

  localparam logic [PULSE_W-1:0] THR_LOW  = 12'd1000;
  localparam logic [PULSE_W-1:0] THR_HIGH = 12'd2000;

  // floor(x / 1000) == (x * RECIP_THR) >> 32 for x < 2^22
  localparam int unsigned       THR_SHIFT = 32;
  localparam logic [22:0]       RECIP_THR = 23'd4294968;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd16383;
  // floor(x / 4000) == (x * RECIP_DUTY) >> 38 for x < 2^26
  localparam int unsigned       DUTY_SHIFT = 38;
  localparam logic [26:0]       RECIP_DUTY = 27'd68719477;

  localparam int unsigned NUM_MOTORS = 4;
  localparam int unsigned NUM_STAGES = 7;

  typedef enum logic [0:0] {
    CFG_IDLE = 1'b0,
    CFG_MAX  = 1'b1
  } cfg_idx_e;

  typedef logic signed [MIX_W-1:0] mix_t;

  typedef struct packed {
    logic mul_en;
    logic out_en;
  } lane_ctrl_t;

endpackage

>>> src/qxm_stream_if.sv
interface qxm_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [qxm_pkg::PULSE_W-1:0]   throttle_pulse;
  logic signed [qxm_pkg::CORR_W-1:0] pitch_corr;
  logic signed [qxm_pkg::CORR_W-1:0] roll_corr;
  logic signed [qxm_pkg::CORR_W-1:0] yaw_corr;

  modport source (output valid, throttle_pulse, pitch_corr, roll_corr, yaw_corr,
                  input ready);
  modport sink   (input valid, throttle_pulse, pitch_corr, roll_corr, yaw_corr,
                  output ready);
endinterface

interface qxm_mot_if;
  logic                        valid;
  logic                        ready;
  logic [qxm_pkg::PULSE_W-1:0] front_right_pulse;
  logic [qxm_pkg::PULSE_W-1:0] rear_right_pulse;
  logic [qxm_pkg::PULSE_W-1:0] rear_left_pulse;
  logic [qxm_pkg::PULSE_W-1:0] front_left_pulse;
  logic [qxm_pkg::DUTY_W-1:0]  front_right_duty;
  logic [qxm_pkg::DUTY_W-1:0]  rear_right_duty;
  logic [qxm_pkg::DUTY_W-1:0]  rear_left_duty;
  logic [qxm_pkg::DUTY_W-1:0]  front_left_duty;

  modport source (output valid, front_right_pulse, rear_right_pulse, rear_left_pulse,
                  front_left_pulse, front_right_duty, rear_right_duty,
                  rear_left_duty, front_left_duty,
                  input ready);
  modport sink   (input valid, front_right_pulse, rear_right_pulse, rear_left_pulse,
                  front_left_pulse, front_right_duty, rear_right_duty,
                  rear_left_duty, front_left_duty,
                  output ready);
endinterface

>>> src/quad_x_motor_mixer.sv
// Seven-stage pipeline: a beat accepted into the first stage passes through
// all seven registered stages before it shows on the output.
// Throughput is one beat per cycle when the output is not stalled; a stall
// holds only the stages behind an occupied one, so bubbles close up.
// rst_ni (async, active low) empties the pipeline and loads idle/max pulse
// with 1100 and 2000.
module quad_x_motor_mixer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  qxm_pkg::cfg_idx_e           cfg_idx_i,
  input  logic [qxm_pkg::PULSE_W-1:0] cfg_data_i,
  qxm_cmd_if.sink                     mix_in,
  qxm_mot_if.source                   mix_out
);
  import qxm_pkg::*;

  localparam int unsigned TC_W   = 10;
  localparam int unsigned DIFF_W = PULSE_W + 1;
  localparam int unsigned PROD_W = 24;
  localparam int unsigned MAG_W  = 22;
  localparam int unsigned RP_W   = MAG_W + 23;

  logic [PULSE_W-1:0] idle_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= IDLE_RST;
      max_q  <= MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDLE: idle_q <= cfg_data_i;
        CFG_MAX:  max_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // pipeline control
  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || mix_out.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= mix_in.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign mix_in.ready  = en[0];
  assign mix_out.valid = v_q[NUM_STAGES-1];

  // stage 1: clamp throttle, scale by span
  logic [PULSE_W-1:0]       t_cl;
  logic [TC_W-1:0]          tc;
  logic signed [DIFF_W-1:0] span;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [CORR_W-1:0] p1_q, r1_q, y1_q;

  always_comb begin
    if (mix_in.throttle_pulse < THR_LOW) t_cl = THR_LOW;
    else if (mix_in.throttle_pulse > THR_HIGH) t_cl = THR_HIGH;
    else t_cl = mix_in.throttle_pulse;
    tc     = TC_W'(t_cl - THR_LOW);
    span   = $signed({1'b0, max_q}) - $signed({1'b0, idle_q});
    prod_d = $signed({{(PROD_W-TC_W){1'b0}}, tc}) *
             $signed({{(PROD_W-DIFF_W){span[DIFF_W-1]}}, span});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
      p1_q   <= mix_in.pitch_corr;
      r1_q   <= mix_in.roll_corr;
      y1_q   <= mix_in.yaw_corr;
    end
  end

  // stage 2: divide magnitude by 1000
  logic [MAG_W-1:0]         mag;
  logic [RP_W-1:0]          rprod;
  logic [PULSE_W-1:0]       q2_q;
  logic                     neg2_q;
  logic signed [CORR_W-1:0] p2_q, r2_q, y2_q;

  assign mag   = prod_q[PROD_W-1] ? MAG_W'(-prod_q) : MAG_W'(prod_q);
  assign rprod = RP_W'(mag) * RP_W'(RECIP_THR);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      q2_q   <= rprod[THR_SHIFT +: PULSE_W];
      neg2_q <= prod_q[PROD_W-1];
      p2_q   <= p1_q;
      r2_q   <= r1_q;
      y2_q   <= y1_q;
    end
  end

  // stage 3: throttle level and X-frame sums
  mix_t thr;
  mix_t pe, re, ye;
  mix_t m3_d [NUM_MOTORS];
  mix_t m3_q [NUM_MOTORS];

  always_comb begin
    thr = (neg2_q ? -mix_t'({1'b0, q2_q}) : mix_t'({1'b0, q2_q})) +
          mix_t'({1'b0, idle_q});
    pe = MIX_W'(p2_q);
    re = MIX_W'(r2_q);
    ye = MIX_W'(y2_q);
    m3_d[0] = thr - pe + re - ye;
    m3_d[1] = thr + pe + re + ye;
    m3_d[2] = thr + pe - re - ye;
    m3_d[3] = thr - pe - re + ye;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) m3_q <= m3_d;
  end

  // stage 4: peak and excess over max
  mix_t pk_a, pk_b, peak, over;
  mix_t excess_q;
  mix_t m4_q [NUM_MOTORS];

  always_comb begin
    pk_a = (m3_q[1] > m3_q[0]) ? m3_q[1] : m3_q[0];
    pk_b = (m3_q[3] > m3_q[2]) ? m3_q[3] : m3_q[2];
    peak = (pk_b > pk_a) ? pk_b : pk_a;
    over = peak - mix_t'({1'b0, max_q});
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      excess_q <= (over > 0) ? over : '0;
      m4_q     <= m3_q;
    end
  end

  // stage 5: desaturate and limit
  mix_t               adj   [NUM_MOTORS];
  logic [PULSE_W-1:0] pl5_d [NUM_MOTORS];
  logic [PULSE_W-1:0] pl5_q [NUM_MOTORS];

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      adj[i] = m4_q[i] - excess_q;
      if (adj[i] < mix_t'({1'b0, idle_q})) pl5_d[i] = idle_q;
      else if (adj[i] > mix_t'({1'b0, max_q})) pl5_d[i] = max_q;
      else pl5_d[i] = adj[i][PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) pl5_q <= pl5_d;
  end

  // stages 6 and 7: duty per motor
  lane_ctrl_t         lane_ctrl;
  logic [PULSE_W-1:0] pulse_out [NUM_MOTORS];
  logic [DUTY_W-1:0]  duty_out  [NUM_MOTORS];

  assign lane_ctrl.mul_en = en[5];
  assign lane_ctrl.out_en = en[6];

  for (genvar g = 0; g < NUM_MOTORS; g++) begin : g_lane
    qxm_duty_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .pulse_i (pl5_q[g]),
      .pulse_o (pulse_out[g]),
      .duty_o  (duty_out[g])
    );
  end

  assign mix_out.front_right_pulse = pulse_out[0];
  assign mix_out.rear_right_pulse  = pulse_out[1];
  assign mix_out.rear_left_pulse   = pulse_out[2];
  assign mix_out.front_left_pulse  = pulse_out[3];
  assign mix_out.front_right_duty  = duty_out[0];
  assign mix_out.rear_right_duty   = duty_out[1];
  assign mix_out.rear_left_duty    = duty_out[2];
  assign mix_out.front_left_duty   = duty_out[3];

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_in.valid && mix_in.ready |=> v_q[0])
    else $error("accepted beat not in first stage");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !en[0] |-> v_q[1] && !en[1])
    else $error("first stage stalled without a blocked successor");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NUM_STAGES-1] && !mix_out.ready |=> v_q[NUM_STAGES-1] &&
      $stable(duty_out[0]) && $stable(pulse_out[3]))
    else $error("stalled output beat changed");

  a_excess_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[3] |-> !excess_q[MIX_W-1])
    else $error("negative desaturation excess");

endmodule

>>> src/qxm_duty_lane.sv
module qxm_duty_lane (
  input  logic                        clk_i,
  input  qxm_pkg::lane_ctrl_t         ctrl_i,
  input  logic [qxm_pkg::PULSE_W-1:0] pulse_i,
  output logic [qxm_pkg::PULSE_W-1:0] pulse_o,
  output logic [qxm_pkg::DUTY_W-1:0]  duty_o
);
  import qxm_pkg::*;

  localparam int unsigned X_W = PULSE_W + DUTY_W;
  localparam int unsigned P_W = X_W + 27;
  localparam int unsigned Q_W = P_W - DUTY_SHIFT;

  logic [X_W-1:0]     scaled;
  logic [P_W-1:0]     prod;
  logic [Q_W-1:0]     quot_d, quot_q;
  logic [PULSE_W-1:0] pulse_mid_q, pulse_q;
  logic [DUTY_W-1:0]  duty_d, duty_q;

  // pulse * 16383 as shift and subtract
  assign scaled = {pulse_i, {DUTY_W{1'b0}}} - X_W'(pulse_i);
  assign prod   = P_W'(scaled) * P_W'(RECIP_DUTY);
  assign quot_d = prod[P_W-1:DUTY_SHIFT];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      quot_q      <= quot_d;
      pulse_mid_q <= pulse_i;
    end
  end

  assign duty_d = (quot_q > Q_W'(DUTY_FULL)) ? DUTY_FULL : quot_q[DUTY_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_en) begin
      duty_q  <= duty_d;
      pulse_q <= pulse_mid_q;
    end
  end

  assign pulse_o = pulse_q;
  assign duty_o  = duty_q;

endmodule
